[design/ccp_pkg.sv]
// Shared types, default parameters and width helpers for the circumcircle pipeline.
package ccp_pkg;

  // Default configuration and fixed field widths
  localparam int DEF_COORD_BITS = 16;
  localparam int DEF_FRAC_BITS  = 8;
  localparam int FIELD_W        = 16;
  localparam int OUT_W          = 32;
  localparam int QW             = 32;

  // One input beat: three points
  typedef struct packed {
    logic signed [FIELD_W-1:0] p1_x;
    logic signed [FIELD_W-1:0] p1_y;
    logic signed [FIELD_W-1:0] p2_x;
    logic signed [FIELD_W-1:0] p2_y;
    logic signed [FIELD_W-1:0] p3_x;
    logic signed [FIELD_W-1:0] p3_y;
  } point_set_t;

  // One result beat
  typedef struct packed {
    logic signed [OUT_W-1:0] center_x;
    logic signed [OUT_W-1:0] center_y;
    logic [OUT_W-1:0]        radius;
    logic                    collinear;
    logic                    saturated;
  } circle_t;

  // Twice |det|, unsigned
  function automatic int den_w(input int c);
    return 2 * c + 3;
  endfunction

  // Magnitude of the shifted centre numerator
  function automatic int num_w(input int c, input int f);
    return 3 * c + 6 + f;
  endfunction

  // Sum of the squared bisector numerators
  function automatic int sq_w(input int c);
    return 6 * c + 11;
  endfunction

  // Root width for the scaled sum of squares
  function automatic int root_w(input int c, input int f);
    return (sq_w(c) + 2 * f + 1) >> 1;
  endfunction

endpackage

[design/ccp_front.sv]
// Front pipeline: edge vectors, determinant, bisector numerators and squares.
module ccp_front #(
  parameter int COORD_BITS = ccp_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS  = ccp_pkg::DEF_FRAC_BITS
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         load,
  input  ccp_pkg::point_set_t                          points,
  output logic                                         valid,
  output logic [ccp_pkg::num_w(COORD_BITS, FRAC_BITS)-1:0] magx,
  output logic [ccp_pkg::num_w(COORD_BITS, FRAC_BITS)-1:0] magy,
  output logic                                         negx,
  output logic                                         negy,
  output logic [ccp_pkg::den_w(COORD_BITS)-1:0]        den,
  output logic                                         col,
  output logic signed [COORD_BITS-1:0]                 x1,
  output logic signed [COORD_BITS-1:0]                 y1,
  output logic [ccp_pkg::sq_w(COORD_BITS)-1:0]         sq_sum
);
  import ccp_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int DFW  = C + 1;
  localparam int PW   = 2 * C + 2;
  localparam int LW   = 2 * C + 3;
  localparam int MW   = 3 * C + 4;
  localparam int NXW  = 3 * C + 5;
  localparam int DENW = den_w(C);
  localparam int XDW  = C + DENW + 1;
  localparam int SUMW = 3 * C + 6;
  localparam int NUMW = num_w(C, FRAC_BITS);
  localparam int AW   = NXW;
  localparam int H    = (AW + 1) / 2;
  localparam int SW   = sq_w(C);

  // Stage 1: take low COORD_BITS of each field, edge vectors from p1
  logic                  v1;
  logic signed [C-1:0]   s1_x1, s1_y1;
  logic signed [DFW-1:0] s1_ax, s1_ay, s1_bx, s1_by;
  logic signed [C-1:0]   c_x1, c_y1, c_x2, c_y2, c_x3, c_y3;

  assign c_x1 = $signed(C'($unsigned(points.p1_x)));
  assign c_y1 = $signed(C'($unsigned(points.p1_y)));
  assign c_x2 = $signed(C'($unsigned(points.p2_x)));
  assign c_y2 = $signed(C'($unsigned(points.p2_y)));
  assign c_x3 = $signed(C'($unsigned(points.p3_x)));
  assign c_y3 = $signed(C'($unsigned(points.p3_y)));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= load;
    end
  end

  always_ff @(posedge clk) begin
    s1_x1 <= c_x1;
    s1_y1 <= c_y1;
    s1_ax <= DFW'(c_x2) - DFW'(c_x1);
    s1_ay <= DFW'(c_y2) - DFW'(c_y1);
    s1_bx <= DFW'(c_x3) - DFW'(c_x1);
    s1_by <= DFW'(c_y3) - DFW'(c_y1);
  end

  // Stage 2: squares and cross products
  logic                  v2;
  logic signed [C-1:0]   s2_x1, s2_y1;
  logic signed [DFW-1:0] s2_ax, s2_ay, s2_bx, s2_by;
  logic signed [PW-1:0]  s2_axx, s2_ayy, s2_bxx, s2_byy, s2_pab, s2_pba;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    s2_x1  <= s1_x1;
    s2_y1  <= s1_y1;
    s2_ax  <= s1_ax;
    s2_ay  <= s1_ay;
    s2_bx  <= s1_bx;
    s2_by  <= s1_by;
    s2_axx <= s1_ax * s1_ax;
    s2_ayy <= s1_ay * s1_ay;
    s2_bxx <= s1_bx * s1_bx;
    s2_byy <= s1_by * s1_by;
    s2_pab <= s1_ax * s1_by;
    s2_pba <= s1_ay * s1_bx;
  end

  // Stage 3: squared edge lengths and determinant
  logic                  v3;
  logic signed [C-1:0]   s3_x1, s3_y1;
  logic signed [DFW-1:0] s3_ax, s3_ay, s3_bx, s3_by;
  logic signed [LW-1:0]  s3_l1, s3_l2, s3_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    s3_x1  <= s2_x1;
    s3_y1  <= s2_y1;
    s3_ax  <= s2_ax;
    s3_ay  <= s2_ay;
    s3_bx  <= s2_bx;
    s3_by  <= s2_by;
    s3_l1  <= LW'(s2_axx) + LW'(s2_ayy);
    s3_l2  <= LW'(s2_bxx) + LW'(s2_byy);
    s3_det <= LW'(s2_pab) - LW'(s2_pba);
  end

  // Stage 4: edge times length products, denominator 2*|det|
  logic                  v4;
  logic signed [C-1:0]   s4_x1, s4_y1;
  logic signed [MW-1:0]  s4_m1, s4_m2, s4_m3, s4_m4;
  logic [DENW-1:0]       s4_den;
  logic                  s4_dneg, s4_col;
  logic signed [LW-1:0]  dabs;

  assign dabs = s3_det[LW-1] ? -s3_det : s3_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    s4_x1   <= s3_x1;
    s4_y1   <= s3_y1;
    s4_m1   <= s3_by * s3_l1;
    s4_m2   <= s3_ay * s3_l2;
    s4_m3   <= s3_ax * s3_l2;
    s4_m4   <= s3_bx * s3_l1;
    s4_den  <= DENW'({dabs[LW-2:0], 1'b0});
    s4_dneg <= s3_det[LW-1];
    s4_col  <= (s3_det == '0);
  end

  // Stage 5: bisector numerators with sign folded in, p1 times denominator
  logic                  v5;
  logic signed [C-1:0]   s5_x1, s5_y1;
  logic signed [NXW-1:0] s5_nx, s5_ny;
  logic signed [XDW-1:0] s5_xd, s5_yd;
  logic [DENW-1:0]       s5_den;
  logic                  s5_col;
  logic signed [DENW:0]  den_s;

  assign den_s = $signed({1'b0, s4_den});

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    s5_x1  <= s4_x1;
    s5_y1  <= s4_y1;
    s5_nx  <= s4_dneg ? NXW'(s4_m2) - NXW'(s4_m1) : NXW'(s4_m1) - NXW'(s4_m2);
    s5_ny  <= s4_dneg ? NXW'(s4_m4) - NXW'(s4_m3) : NXW'(s4_m3) - NXW'(s4_m4);
    s5_xd  <= s4_x1 * den_s;
    s5_yd  <= s4_y1 * den_s;
    s5_den <= s4_den;
    s5_col <= s4_col;
  end

  // Stage 6: scaled centre numerators, floor magnitudes, absolute numerators
  logic                   v6;
  logic signed [C-1:0]    s6_x1, s6_y1;
  logic [NUMW-1:0]        s6_magx, s6_magy;
  logic                   s6_negx, s6_negy;
  logic [AW-1:0]          s6_anx, s6_any;
  logic [DENW-1:0]        s6_den;
  logic                   s6_col;
  logic signed [SUMW-1:0] sumx, sumy;
  logic signed [NUMW-1:0] shx, shy;

  assign sumx = SUMW'(s5_xd) + SUMW'(s5_nx);
  assign sumy = SUMW'(s5_yd) + SUMW'(s5_ny);
  assign shx  = NUMW'(sumx) <<< FRAC_BITS;
  assign shy  = NUMW'(sumy) <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
  end

  // negative numerator: floor(n/d) = -ceil(-n/d), magnitude is -n + d - 1
  always_ff @(posedge clk) begin
    s6_x1   <= s5_x1;
    s6_y1   <= s5_y1;
    s6_negx <= sumx[SUMW-1];
    s6_negy <= sumy[SUMW-1];
    s6_magx <= sumx[SUMW-1] ? $unsigned(-shx) + NUMW'(s5_den) - NUMW'(1) : $unsigned(shx);
    s6_magy <= sumy[SUMW-1] ? $unsigned(-shy) + NUMW'(s5_den) - NUMW'(1) : $unsigned(shy);
    s6_anx  <= $unsigned(s5_nx[NXW-1] ? -s5_nx : s5_nx);
    s6_any  <= $unsigned(s5_ny[NXW-1] ? -s5_ny : s5_ny);
    s6_den  <= s5_den;
    s6_col  <= s5_col;
  end

  // Stage 7: split squares into half-width partial products
  logic                      v7;
  logic signed [C-1:0]       s7_x1, s7_y1;
  logic [NUMW-1:0]           s7_magx, s7_magy;
  logic                      s7_negx, s7_negy;
  logic [DENW-1:0]           s7_den;
  logic                      s7_col;
  logic [2*(AW-H)-1:0]       s7_xhh, s7_yhh;
  logic [AW-1:0]             s7_xhl, s7_yhl;
  logic [2*H-1:0]            s7_xll, s7_yll;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    s7_x1   <= s6_x1;
    s7_y1   <= s6_y1;
    s7_magx <= s6_magx;
    s7_magy <= s6_magy;
    s7_negx <= s6_negx;
    s7_negy <= s6_negy;
    s7_den  <= s6_den;
    s7_col  <= s6_col;
    s7_xhh  <= s6_anx[AW-1:H] * s6_anx[AW-1:H];
    s7_xhl  <= s6_anx[AW-1:H] * s6_anx[H-1:0];
    s7_xll  <= s6_anx[H-1:0] * s6_anx[H-1:0];
    s7_yhh  <= s6_any[AW-1:H] * s6_any[AW-1:H];
    s7_yhl  <= s6_any[AW-1:H] * s6_any[H-1:0];
    s7_yll  <= s6_any[H-1:0] * s6_any[H-1:0];
  end

  // Stage 8: recombine partial products into nx^2 + ny^2
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    x1     <= s7_x1;
    y1     <= s7_y1;
    magx   <= s7_magx;
    magy   <= s7_magy;
    negx   <= s7_negx;
    negy   <= s7_negy;
    den    <= s7_den;
    col    <= s7_col;
    sq_sum <= (SW'(s7_xhh) << (2 * H)) + (SW'(s7_xhl) << (H + 1)) + SW'(s7_xll)
            + (SW'(s7_yhh) << (2 * H)) + (SW'(s7_yhl) << (H + 1)) + SW'(s7_yll);
  end

endmodule

[design/ccp_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
module ccp_isqrt #(
  parameter int RW   = 62,
  parameter int TAGW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [2*RW-1:0]   value,
  input  logic [TAGW-1:0]   tag,
  output logic              valid,
  output logic [RW-1:0]     root,
  output logic [TAGW-1:0]   tag_d
);

  logic              v_q    [RW];
  logic [RW+2:0]     rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [2*RW-1:0]   val_q  [RW];
  logic [TAGW-1:0]   tag_q  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_step
    logic            v_in;
    logic [RW+2:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] val_in;
    logic [TAGW-1:0] tag_in;
    logic [RW+2:0]   rem2;
    logic [RW+2:0]   trial;
    logic            ge;

    if (i == 0) begin : g_first
      assign v_in    = load;
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = value;
      assign tag_in  = tag;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign val_in  = val_q[i-1];
      assign tag_in  = tag_q[i-1];
    end

    // bring down the next bit pair, try root*4+1
    assign rem2  = {rem_in[RW:0], val_in[2*RW-1-2*i -: 2]};
    assign trial = (RW+3)'({root_in, 2'b01});
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[i]  <= ge ? rem2 - trial : rem2;
      root_q[i] <= {root_in[RW-2:0], ge};
      val_q[i]  <= val_in;
      tag_q[i]  <= tag_in;
    end
  end

  assign valid = v_q[RW-1];
  assign root  = root_q[RW-1];
  assign tag_d = tag_q[RW-1];

endmodule

[design/ccp_div.sv]
// Pipelined restoring divider: 32-bit quotient with overflow flag.
module ccp_div #(
  parameter int NW   = 70,
  parameter int DW   = 35,
  parameter int TAGW = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic [NW-1:0]          num,
  input  logic [DW-1:0]          den,
  input  logic [TAGW-1:0]        tag,
  output logic                   valid,
  output logic [ccp_pkg::QW-1:0] quo,
  output logic                   ovf,
  output logic [TAGW-1:0]        tag_d
);
  import ccp_pkg::*;

  localparam int XW = NW + QW;

  logic            v_q    [QW+1];
  logic [DW-1:0]   rem_q  [QW+1];
  logic [QW-1:0]   low_q  [QW+1];
  logic [QW-1:0]   quo_q  [QW+1];
  logic [DW-1:0]   den_q  [QW+1];
  logic            ovf_q  [QW+1];
  logic [TAGW-1:0] tag_q  [QW+1];

  logic [XW-1:0]   ext;
  logic [NW-1:0]   hi;

  // Stage 0: quotient >= 2^32 exactly when num >> 32 >= den
  assign ext = XW'(num);
  assign hi  = ext[XW-1:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= load;
    end
  end

  always_ff @(posedge clk) begin
    rem_q[0] <= DW'(hi);
    low_q[0] <= ext[QW-1:0];
    quo_q[0] <= '0;
    den_q[0] <= den;
    ovf_q[0] <= ((NW+DW)'(hi) >= (NW+DW)'(den));
    tag_q[0] <= tag;
  end

  // One quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DW:0] rem2;
    logic        ge;

    assign rem2 = {rem_q[k-1], low_q[k-1][QW-k]};
    assign ge   = (rem2 >= {1'b0, den_q[k-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_q[k] <= DW'(ge ? rem2 - {1'b0, den_q[k-1]} : rem2);
      low_q[k] <= low_q[k-1];
      quo_q[k] <= {quo_q[k-1][QW-2:0], ge};
      den_q[k] <= den_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
      tag_q[k] <= tag_q[k-1];
    end
  end

  assign valid = v_q[QW];
  assign quo   = quo_q[QW];
  assign ovf   = ovf_q[QW];
  assign tag_d = tag_q[QW];

endmodule

[design/circumcircle_of_three_points.sv]
// Top level: circumcircle of three points, fully pipelined.
//
// Input channel: drive a point triple on points and raise start; the beat is
// taken at the rising edge where start is high and busy is low. busy is high
// only while rst is asserted, so a new triple may enter on every clock.
// Output channel: done is high for exactly one cycle with the result on
// circle; the receiver must take it then, there is no back-pressure.
// Throughput: one triple per cycle. A beat passes through 8 front stages
// (products, numerators, squares), RW stages of the digit-by-digit square
// root, where RW = (6*COORD_BITS + 11 + 2*FRAC_BITS + 1) / 2 is the root
// width, and 33 stages of the restoring dividers that run for centre x,
// centre y and radius side by side, plus the output register.
// Reset (synchronous, active high) clears every valid bit, so beats in flight
// are dropped and no result strobe follows; payload registers are not reset.
// Results leave in the order the triples entered.
module circumcircle_of_three_points #(
  parameter int COORD_BITS = ccp_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS  = ccp_pkg::DEF_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ccp_pkg::point_set_t points,
  output logic                done,
  output ccp_pkg::circle_t    circle
);
  import ccp_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int NUMW = num_w(C, FRAC_BITS);
  localparam int DENW = den_w(C);
  localparam int SW   = sq_w(C);
  localparam int RW   = root_w(C, FRAC_BITS);
  localparam int TAGW = 2 * NUMW + 3 + DENW + 2 * C;
  localparam int RTW  = 1 + 2 * C;
  localparam int LAT  = 42 + RW;
  localparam int XW   = C + FRAC_BITS + 1;
  localparam int EW   = (XW > 33) ? XW : 33;
  localparam logic signed [EW-1:0] SMAX = EW'(64'sh7FFF_FFFF);
  localparam logic signed [EW-1:0] SMIN = -SMAX - EW'(1);

  // Front end
  logic                f_valid;
  logic [NUMW-1:0]     f_magx, f_magy;
  logic                f_negx, f_negy;
  logic [DENW-1:0]     f_den;
  logic                f_col;
  logic signed [C-1:0] f_x1, f_y1;
  logic [SW-1:0]       f_sq;

  assign busy = rst;

  ccp_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .load   (start && !busy),
    .points (points),
    .valid  (f_valid),
    .magx   (f_magx),
    .magy   (f_magy),
    .negx   (f_negx),
    .negy   (f_negy),
    .den    (f_den),
    .col    (f_col),
    .x1     (f_x1),
    .y1     (f_y1),
    .sq_sum (f_sq)
  );

  // Square root of (nx^2 + ny^2) * 4^FRAC_BITS
  logic [2*RW-1:0]     sq_val;
  logic                r_valid;
  logic [RW-1:0]       r_root;
  logic [TAGW-1:0]     r_tag;
  logic [NUMW-1:0]     r_magx, r_magy;
  logic                r_negx, r_negy;
  logic [DENW-1:0]     r_den;
  logic                r_col;
  logic signed [C-1:0] r_x1, r_y1;

  assign sq_val = (2*RW)'(f_sq) << (2 * FRAC_BITS);

  ccp_isqrt #(
    .RW   (RW),
    .TAGW (TAGW)
  ) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .load  (f_valid),
    .value (sq_val),
    .tag   ({f_magx, f_magy, f_negx, f_negy, f_den, f_col, f_x1, f_y1}),
    .valid (r_valid),
    .root  (r_root),
    .tag_d (r_tag)
  );

  assign {r_magx, r_magy, r_negx, r_negy, r_den, r_col, r_x1, r_y1} = r_tag;

  // Three dividers by 2*|det|
  logic            vx, vy, vr;
  logic [QW-1:0]   qx, qy, qr;
  logic            ox, oy, orad;
  logic            d_negx, d_negy;
  logic [RTW-1:0]  d_tag;
  logic            d_col;
  logic signed [C-1:0] d_x1, d_y1;

  ccp_div #(.NW(NUMW), .DW(DENW), .TAGW(1)) u_div_x (
    .clk (clk), .rst (rst), .load (r_valid), .num (r_magx), .den (r_den),
    .tag (r_negx), .valid (vx), .quo (qx), .ovf (ox), .tag_d (d_negx)
  );

  ccp_div #(.NW(NUMW), .DW(DENW), .TAGW(1)) u_div_y (
    .clk (clk), .rst (rst), .load (r_valid), .num (r_magy), .den (r_den),
    .tag (r_negy), .valid (vy), .quo (qy), .ovf (oy), .tag_d (d_negy)
  );

  ccp_div #(.NW(RW), .DW(DENW), .TAGW(RTW)) u_div_r (
    .clk (clk), .rst (rst), .load (r_valid), .num (r_root), .den (r_den),
    .tag ({r_col, r_x1, r_y1}), .valid (vr), .quo (qr), .ovf (orad), .tag_d (d_tag)
  );

  assign {d_col, d_x1, d_y1} = d_tag;

  // Floor, sign and saturation of the final beat
  logic signed [EW-1:0] px, py;
  circle_t              circle_next;
  logic                 sx, sy, sr;

  assign px = EW'(d_x1) <<< FRAC_BITS;
  assign py = EW'(d_y1) <<< FRAC_BITS;

  always_comb begin
    circle_next = '0;
    sx = 1'b0;
    sy = 1'b0;
    sr = 1'b0;
    if (d_col) begin
      // collinear: centre at p1, radius zero
      if (px > SMAX) begin
        sx = 1'b1;
        circle_next.center_x = 32'sh7FFF_FFFF;
      end else if (px < SMIN) begin
        sx = 1'b1;
        circle_next.center_x = 32'sh8000_0000;
      end else begin
        circle_next.center_x = OUT_W'(px);
      end
      if (py > SMAX) begin
        sy = 1'b1;
        circle_next.center_y = 32'sh7FFF_FFFF;
      end else if (py < SMIN) begin
        sy = 1'b1;
        circle_next.center_y = 32'sh8000_0000;
      end else begin
        circle_next.center_y = OUT_W'(py);
      end
      circle_next.radius    = '0;
      circle_next.collinear = 1'b1;
    end else begin
      if (d_negx) begin
        sx = ox || (qx[QW-1] && (qx[QW-2:0] != '0));
        circle_next.center_x = sx ? 32'sh8000_0000 : $signed(-qx);
      end else begin
        sx = ox || qx[QW-1];
        circle_next.center_x = sx ? 32'sh7FFF_FFFF : $signed(qx);
      end
      if (d_negy) begin
        sy = oy || (qy[QW-1] && (qy[QW-2:0] != '0));
        circle_next.center_y = sy ? 32'sh8000_0000 : $signed(-qy);
      end else begin
        sy = oy || qy[QW-1];
        circle_next.center_y = sy ? 32'sh7FFF_FFFF : $signed(qy);
      end
      sr = orad;
      circle_next.radius    = orad ? '1 : qr;
      circle_next.collinear = 1'b0;
    end
    circle_next.saturated = sx || sy || sr;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vr;
    end
  end

  always_ff @(posedge clk) begin
    circle <= circle_next;
  end

  // The three dividers run in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    (vx == vr) && (vy == vr))
    else $error("divider valid bits out of step");

  // A collinear beat always reports zero radius
  a_col_radius: assert property (@(posedge clk) disable iff (rst)
    done && circle.collinear |-> circle.radius == '0)
    else $error("collinear result with nonzero radius");

  // Every result strobe comes from a beat taken a fixed time earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result beat without matching input beat");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the circumcircle_of_three_points pipeline.
`timescale 1ns / 100ps

module testbench;
  import ccp_pkg::*;

  typedef logic signed [255:0] wide_t;

  // Directed stimulus row: expectation typed in only where trivially known
  typedef struct {
    point_set_t pts;
    bit         typed;
    circle_t    want;
  } stim_row_t;

  localparam int  NUM_RANDOM  = 1100;
  localparam int  RESULT_LAT  = 103;
  localparam longint CYCLE_LIMIT = 200000;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  point_set_t points;
  logic       done;
  circle_t    circle;

  circle_t    circles_due[$];
  int         errors;
  longint     cycles;

  circumcircle_of_three_points dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .points (points),
    .done   (done),
    .circle (circle)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Floor square root of a 64-bit value
  function automatic logic [31:0] floor_root(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] trial;
    res = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = res | (64'd1 << i);
      if (trial * trial <= v) res = trial;
    end
    return res[31:0];
  endfunction

  // floor(num / den) for den > 0, clipped to signed 32 bits
  function automatic logic [31:0] floor_clip(input wide_t num, input wide_t den,
                                             inout bit clipped);
    wide_t q;
    q = num / den;
    if (num < 0 && q * den != num) q = q - 1;
    if (q > wide_t'(32'sh7FFF_FFFF)) begin
      clipped = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (q < -(wide_t'(1) <<< 31)) begin
      clipped = 1'b1;
      return 32'h8000_0000;
    end
    return q[31:0];
  endfunction

  // Exact circumcircle in Q.8 fixed point
  function automatic circle_t circumcircle(input point_set_t p);
    circle_t c;
    wide_t x1, y1, ax, ay, bx, by, det, len1, len2, bis_x, bis_y, den, rr, dd, q;
    bit clipped;
    x1  = p.p1_x;
    y1  = p.p1_y;
    ax  = wide_t'(p.p2_x) - x1;
    ay  = wide_t'(p.p2_y) - y1;
    bx  = wide_t'(p.p3_x) - x1;
    by  = wide_t'(p.p3_y) - y1;
    det = ax * by - ay * bx;
    clipped = 1'b0;
    c = '0;
    if (det == 0) begin
      // degenerate: center at p1, never out of range at 16-bit coordinates
      c.center_x  = floor_clip(x1 <<< DEF_FRAC_BITS, wide_t'(1), clipped);
      c.center_y  = floor_clip(y1 <<< DEF_FRAC_BITS, wide_t'(1), clipped);
      c.collinear = 1'b1;
      c.saturated = clipped;
      return c;
    end
    len1  = ax * ax + ay * ay;
    len2  = bx * bx + by * by;
    bis_x = by * len1 - ay * len2;
    bis_y = ax * len2 - bx * len1;
    den   = 2 * det;
    if (det < 0) begin
      den   = -den;
      bis_x = -bis_x;
      bis_y = -bis_y;
    end
    c.center_x = floor_clip((x1 * den + bis_x) <<< DEF_FRAC_BITS, den, clipped);
    c.center_y = floor_clip((y1 * den + bis_y) <<< DEF_FRAC_BITS, den, clipped);
    rr = (bis_x * bis_x + bis_y * bis_y) <<< (2 * DEF_FRAC_BITS);
    dd = den * den;
    q  = rr / dd;
    if ((q >>> 64) != 0) begin
      clipped  = 1'b1;
      c.radius = 32'hFFFF_FFFF;
    end else begin
      c.radius = floor_root(q[63:0]);
    end
    c.saturated = clipped;
    return c;
  endfunction

  function automatic point_set_t make_pts(input int a, input int b, input int c2,
                                          input int d, input int e, input int f);
    point_set_t p;
    p.p1_x = a[15:0]; p.p1_y = b[15:0];
    p.p2_x = c2[15:0]; p.p2_y = d[15:0];
    p.p3_x = e[15:0]; p.p3_y = f[15:0];
    return p;
  endfunction

  function automatic logic [15:0] rnd_coord(input int span);
    int v;
    if (span == 0) return 16'($urandom());
    v = $urandom_range(2 * span) - span;
    return v[15:0];
  endfunction

  // Random triple: general, small, collinear or coincident
  function automatic point_set_t random_pts();
    point_set_t p;
    int kind, span, k;
    kind = $urandom_range(9);
    span = ($urandom_range(1) == 1) ? 0 : (1 << $urandom_range(2, 14));
    p = make_pts(0, 0, 0, 0, 0, 0);
    p.p1_x = rnd_coord(span); p.p1_y = rnd_coord(span);
    p.p2_x = rnd_coord(span); p.p2_y = rnd_coord(span);
    p.p3_x = rnd_coord(span); p.p3_y = rnd_coord(span);
    if (kind == 0) begin
      // third point on the line through the first two, wrapping kept in 16 bits
      k = $urandom_range(6) - 3;
      p.p3_x = 16'(p.p1_x + k * (p.p2_x - p.p1_x));
      p.p3_y = 16'(p.p1_y + k * (p.p2_y - p.p1_y));
    end else if (kind == 1) begin
      p.p2_x = p.p1_x;
      p.p2_y = p.p1_y;
    end
    return p;
  endfunction

  // Result checker
  always @(posedge clk) begin
    circle_t want;
    if (!rst && done) begin
      if (circles_due.size() == 0) begin
        $display("%0t: result expected none got %p", $time, circle);
        errors++;
      end else begin
        want = circles_due.pop_front();
        if (circle.center_x !== want.center_x) begin
          $display("%0t: center_x expected %0d got %0d", $time, want.center_x,
                   circle.center_x);
          errors++;
        end
        if (circle.center_y !== want.center_y) begin
          $display("%0t: center_y expected %0d got %0d", $time, want.center_y,
                   circle.center_y);
          errors++;
        end
        if (circle.radius !== want.radius) begin
          $display("%0t: radius expected %0d got %0d", $time, want.radius, circle.radius);
          errors++;
        end
        if (circle.collinear !== want.collinear) begin
          $display("%0t: collinear expected %0b got %0b", $time, want.collinear,
                   circle.collinear);
          errors++;
        end
        if (circle.saturated !== want.saturated) begin
          $display("%0t: saturated expected %0b got %0b", $time, want.saturated,
                   circle.saturated);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("circumcircle_of_three_points regression: fail");
      $finish;
    end
  end

  // Present one beat after a random gap; holds until taken
  task automatic send_beat(input point_set_t p, input circle_t want, input int gap);
    bit taken;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    points <= p;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      if (!busy) taken = 1'b1;
    end
    circles_due.push_back(want);
  endtask

  stim_row_t directed[$];

  initial begin
    stim_row_t r;
    point_set_t p;
    int gap;
    errors = 0;
    cycles = 0;
    rst    = 1'b1;
    start  = 1'b0;
    points = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Coincident and collinear points: center at p1, radius zero
    r.typed = 1'b1;
    r.pts = make_pts(0, 0, 0, 0, 0, 0);
    r.want = '{center_x: 0, center_y: 0, radius: 0, collinear: 1, saturated: 0};
    directed.push_back(r);
    r.pts = make_pts(-32768, 32767, -32768, 32767, -32768, 32767);
    r.want = '{center_x: 32'hFF80_0000, center_y: 32'h007F_FF00, radius: 0,
               collinear: 1, saturated: 0};
    directed.push_back(r);
    r.pts = make_pts(32767, -32768, 32767, -32768, 32767, -32768);
    r.want = '{center_x: 32'h007F_FF00, center_y: 32'hFF80_0000, radius: 0,
               collinear: 1, saturated: 0};
    directed.push_back(r);
    r.pts = make_pts(1, 1, 2, 2, 3, 3);
    r.want = '{center_x: 256, center_y: 256, radius: 0, collinear: 1, saturated: 0};
    directed.push_back(r);
    r.pts = make_pts(-32768, -32768, 0, 0, 32767, 32767);
    r.want = '{center_x: 32'hFF80_0000, center_y: 32'hFF80_0000, radius: 0,
               collinear: 1, saturated: 0};
    directed.push_back(r);
    // Predictor-checked rows: right angles, extremes, near-collinear overflow
    r.typed = 1'b0;
    directed.push_back('{make_pts(0, 0, 2, 0, 0, 2), 0, '0});
    directed.push_back('{make_pts(0, 0, 1, 0, 0, 1), 0, '0});
    directed.push_back('{make_pts(-1, -1, 1, -1, -1, 1), 0, '0});
    directed.push_back('{make_pts(-32768, -32768, 32767, -32768, -32768, 32767), 0, '0});
    directed.push_back('{make_pts(32767, 32767, -32768, 32767, 32767, -32768), 0, '0});
    directed.push_back('{make_pts(-32768, 32767, 32767, -32768, 32767, 32767), 0, '0});
    directed.push_back('{make_pts(-32768, -32768, 32767, 32767, 32767, 32766), 0, '0});
    directed.push_back('{make_pts(-32768, -32768, 32767, 32767, 32766, 32767), 0, '0});
    directed.push_back('{make_pts(0, 0, 32767, 1, -32768, 0), 0, '0});
    directed.push_back('{make_pts(-32768, 0, 32767, 0, 0, 1), 0, '0});
    directed.push_back('{make_pts(3, 7, -5, 11, 13, -2), 0, '0});
    directed.push_back('{make_pts(100, 200, 300, 50, -400, -60), 0, '0});

    foreach (directed[i]) begin
      gap = $urandom_range(4);
      send_beat(directed[i].pts,
                directed[i].typed ? directed[i].want : circumcircle(directed[i].pts), gap);
    end

    // Random triples; every eighth block of 32 runs back to back
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 2) begin
        // drain the pipeline before carrying on
        start <= 1'b0;
        while (circles_due.size() != 0) @(posedge clk);
      end
      gap = (((n / 32) % 8) == 3) ? 0 : $urandom_range(4);
      p = random_pts();
      send_beat(p, circumcircle(p), gap);
    end
    start <= 1'b0;

    while (circles_due.size() != 0) @(posedge clk);
    repeat (RESULT_LAT + 20) @(posedge clk);
    if (errors == 0) begin
      $display("circumcircle_of_three_points regression: pass");
    end else begin
      $display("circumcircle_of_three_points regression: fail");
    end
    $finish;
  end

endmodule

[circumcircle_of_three_points.f]
design/ccp_pkg.sv
design/ccp_front.sv
design/ccp_isqrt.sv
design/ccp_div.sv
design/circumcircle_of_three_points.sv
tb/sv/testbench.sv
